FILE: hdl/u8ld_pkg.sv
// shared types, constants and helper functions of the lenient utf-8 decoder
`default_nettype none

package u8ld_pkg;

  // widths of the stream fields
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned OutDW  = 24;

  // replacement character for malformed bytes
  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;
  localparam int unsigned MaxRes = 3;

  // sequence length codes
  localparam logic [2:0] SeqLenBad = 3'd0;
  localparam logic [2:0] SeqLen1   = 3'd1;
  localparam logic [2:0] SeqLen2   = 3'd2;
  localparam logic [2:0] SeqLen3   = 3'd3;
  localparam logic [2:0] SeqLen4   = 3'd4;

  // lead byte class patterns
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Val  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Val  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Val  = 8'hF0;

  // one decoded result
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           sub;
    logic           last;
  } res_t;

  // sequence length selected by a lead byte
  function automatic logic [2:0] seq_len(input logic [ByteW-1:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = SeqLen1;
    end else if ((b & Lead2Mask) == Lead2Val) begin
      len = SeqLen2;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      len = SeqLen3;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      len = SeqLen4;
    end else begin
      len = SeqLenBad;
    end
    return len;
  endfunction

  // merge a lead and its continuation bytes into a code point
  function automatic logic [CpW-1:0] merge_seq(input logic [ByteW-1:0] b0,
                                               input logic [ByteW-1:0] b1,
                                               input logic [ByteW-1:0] b2,
                                               input logic [ByteW-1:0] b3,
                                               input logic [2:0]       len);
    logic [CpW-1:0] cp;
    unique case (len)
      SeqLen2: cp = {10'd0, b0[4:0], b1[5:0]};
      SeqLen3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

  // a lone byte of a tail: ascii passes, anything else is replaced
  function automatic res_t single_res(input logic [ByteW-1:0] b);
    res_t r;
    r.last = 1'b0;
    if (!b[7]) begin
      r.cp  = {13'd0, b};
      r.sub = 1'b0;
    end else begin
      r.cp  = ReplCp;
      r.sub = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_lenient_decoder_unit.sv
// top level of the lenient utf-8 decoder: byte stream in, code points out
`default_nettype none

// Lenient UTF-8 decoder. One byte enters per cycle on the slave stream
// (tlast marks the last byte of a string); decoded code points leave on the
// master stream, with tuser set where U+FFFD replaces a malformed byte and
// tlast set on the last code point of the string. Each byte is decoded in the
// cycle it is accepted and its results (none, one, or up to three at the end
// of a string with an incomplete tail) are written into a four-entry result
// queue that drains one code point per cycle while m_axis_tready is high.
// The sustained rate is one byte per cycle while the output keeps up; tready
// drops only while the queue holds two or more results.
module utf8_lenient_decoder_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [u8ld_pkg::ByteW-1:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                         s_axis_tlast_i,  // last_byte
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output      logic [u8ld_pkg::OutDW-1:0]   m_axis_tdata_o,  // [20:0] code_point, [23:21] zero
  output      logic                         m_axis_tuser_o,  // substituted
  output      logic                         m_axis_tlast_o   // string_end
);
  import u8ld_pkg::*;

  // held sequence state
  logic [ByteW-1:0] held_q [3];
  logic [ByteW-1:0] held_d [3];
  logic [1:0]       hcnt_q, hcnt_d;

  // result queue
  res_t             q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] q_cnt_q;

  logic             in_fire, out_fire;
  res_t             res [MaxRes];
  logic [1:0]       n_res;

  logic [2:0]       len_in, lead_len, tail_len;
  logic [ByteW-1:0] seq1, seq2;
  logic [2:0]       need;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // accept while the queue has room for the largest burst
  assign s_axis_tready_o = (q_cnt_q <= QCntW'(1));

  // byte decode
  always_comb begin
    res[0]   = '{cp: ReplCp, sub: 1'b1, last: 1'b0};
    res[1]   = '{cp: ReplCp, sub: 1'b1, last: 1'b0};
    res[2]   = '{cp: ReplCp, sub: 1'b1, last: 1'b0};
    n_res    = 2'd0;
    held_d   = held_q;
    hcnt_d   = hcnt_q;
    len_in   = seq_len(s_axis_tdata_i);
    lead_len = seq_len(held_q[0]);
    tail_len = seq_len(held_q[1]);
    need     = {1'b0, hcnt_q} + 3'd1;
    seq1     = (hcnt_q == 2'd1) ? s_axis_tdata_i : held_q[1];
    seq2     = (hcnt_q == 2'd2) ? s_axis_tdata_i : held_q[2];

    if (hcnt_q == 2'd0) begin
      if (len_in == SeqLen1) begin
        res[0] = '{cp: {13'd0, s_axis_tdata_i}, sub: 1'b0, last: 1'b0};
        n_res  = 2'd1;
      end else if (len_in == SeqLenBad || s_axis_tlast_i) begin
        n_res = 2'd1;
      end else begin
        held_d[0] = s_axis_tdata_i;
        hcnt_d    = 2'd1;
      end
    end else if (need == lead_len) begin
      // sequence complete
      res[0] = '{cp: merge_seq(held_q[0], seq1, seq2, s_axis_tdata_i, lead_len),
                 sub: 1'b0, last: 1'b0};
      n_res  = 2'd1;
      hcnt_d = 2'd0;
    end else if (!s_axis_tlast_i) begin
      // absorb another continuation byte
      held_d[hcnt_q] = s_axis_tdata_i;
      hcnt_d         = hcnt_q + 2'd1;
    end else begin
      // incomplete tail: lead is replaced, the rest decoded again
      if (hcnt_q == 2'd1) begin
        res[1] = single_res(s_axis_tdata_i);
        n_res  = 2'd2;
      end else if (tail_len == SeqLen2) begin
        res[1] = '{cp: merge_seq(held_q[1], s_axis_tdata_i, s_axis_tdata_i,
                                 s_axis_tdata_i, SeqLen2),
                   sub: 1'b0, last: 1'b0};
        n_res  = 2'd2;
      end else begin
        res[1] = single_res(held_q[1]);
        res[2] = single_res(s_axis_tdata_i);
        n_res  = 2'd3;
      end
    end

    // end of string flag and state clear
    if (s_axis_tlast_i) begin
      hcnt_d = 2'd0;
      if (n_res != 2'd0) begin
        res[n_res - 2'd1].last = 1'b1;
      end
    end
  end

  // held byte storage
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_q <= held_d;
    end
  end

  // held count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 2'd0;
    end else if (in_fire) begin
      hcnt_q <= hcnt_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < MaxRes; k++) begin
        if (2'(k) < n_res) begin
          q_mem_q[wr_ptr_q + QPtrW'(k)] <= res[k];
        end
      end
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      q_cnt_q <= q_cnt_q + (in_fire ? QCntW'(n_res) : QCntW'(0))
                         - (out_fire ? QCntW'(1) : QCntW'(0));
    end
  end

  // output side
  assign m_axis_tvalid_o = (q_cnt_q != QCntW'(0));
  assign m_axis_tdata_o  = {3'd0, q_mem_q[rd_ptr_q].cp};
  assign m_axis_tuser_o  = q_mem_q[rd_ptr_q].sub;
  assign m_axis_tlast_o  = q_mem_q[rd_ptr_q].last;

endmodule

`default_nettype wire

FILE: hdl/u8ld_checker.sv
// port-level checks of the lenient utf-8 decoder, bound to the top level
`default_nettype none

module u8ld_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tready_i,
  input wire logic                       m_axis_tvalid_i,
  input wire logic                       m_axis_tready_i,
  input wire logic [u8ld_pkg::OutDW-1:0] m_axis_tdata_i,
  input wire logic                       m_axis_tuser_i
);
  import u8ld_pkg::*;

  // padding bits above the code point stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[OutDW-1:CpW] == '0)
    else $error("tdata padding not zero");

  // a substituted result always carries the replacement character
  a_sub_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i) |-> m_axis_tdata_i[CpW-1:0] == ReplCp)
    else $error("substituted result is not U+FFFD");

  // input stalls only while results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_i |-> m_axis_tvalid_i)
    else $error("input stalled with empty result queue");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> m_axis_tvalid_i)
    else $error("result withdrawn while stalled");

endmodule

bind utf8_lenient_decoder_unit u8ld_checker u_u8ld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

FILE: tb/sv/utf8_lenient_decoder_unit_tb.sv
// self-checking testbench of the lenient utf-8 decoder top level
module utf8_lenient_decoder_unit_tb;

  import u8ld_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned RandBytes  = 190;

  // one byte request on the slave stream
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } byte_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [ByteW-1:0]   s_axis_tdata_i;   // [7:0] data_byte
  logic               s_axis_tlast_i;   // last_byte
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [OutDW-1:0]   m_axis_tdata_o;   // [20:0] code_point, [23:21] zero
  logic               m_axis_tuser_o;   // substituted
  logic               m_axis_tlast_o;   // string_end

  byte_req_t          byte_reqs[$];
  res_t               cp_expect[$];
  logic [ByteW-1:0]   hold_buf[3];
  int unsigned        hold_cnt;
  int unsigned        err_cnt;
  int unsigned        cycle_cnt;
  int unsigned        sent_cnt;
  logic               in_taken;
  logic               out_taken;
  logic               tx_busy;
  int unsigned        tx_wait;
  int unsigned        rx_wait;
  logic               burst;
  byte_req_t          tx_cur;

  utf8_lenient_decoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sequence length selected by a lead byte, zero when it cannot lead
  function automatic int unsigned lead_len(input logic [ByteW-1:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 0;
  endfunction

  // payload of the lead, then six bits from each following byte
  function automatic logic [CpW-1:0] join_bytes(input logic [31:0] seq, input int unsigned len);
    logic [31:0] acc;
    if (len == 2) acc = seq[7:0] & 8'h1F;
    else if (len == 3) acc = seq[7:0] & 8'h0F;
    else acc = seq[7:0] & 8'h07;
    for (int unsigned i = 1; i < len; i++) acc = (acc << 6) | (seq[8*i +: 8] & 8'h3F);
    return acc[CpW-1:0];
  endfunction

  function automatic void add_cp(input logic [CpW-1:0] cp, input logic sub);
    res_t r;
    r.cp   = cp;
    r.sub  = sub;
    r.last = 1'b0;
    cp_expect.insert(cp_expect.size(), r);
  endfunction

  // expected code points caused by one accepted byte
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic lst);
    int unsigned len;
    int unsigned tlen;
    int unsigned i;
    int unsigned l;
    int unsigned n0;
    logic [31:0] seq;
    logic [31:0] tail;
    res_t        r;
    n0   = cp_expect.size();
    seq  = '0;
    tail = '0;
    if (hold_cnt == 0) begin
      len = lead_len(b);
      if (len == 1) begin
        add_cp({13'd0, b}, 1'b0);
      end else if (len == 0 || lst) begin
        add_cp(ReplCp, 1'b1);
      end else begin
        hold_buf[0] = b;
        hold_cnt    = 1;
      end
    end else begin
      len = lead_len(hold_buf[0]);
      if (hold_cnt + 1 == len) begin
        // sequence complete
        for (i = 0; i < hold_cnt; i++) seq[8*i +: 8] = hold_buf[i];
        seq[8*hold_cnt +: 8] = b;
        add_cp(join_bytes(seq, len), 1'b0);
        hold_cnt = 0;
      end else if (!lst) begin
        hold_buf[hold_cnt] = b;
        hold_cnt++;
      end else begin
        // incomplete tail: lead replaced, the rest decoded again
        add_cp(ReplCp, 1'b1);
        tlen = 0;
        for (i = 1; i < hold_cnt; i++) begin
          tail[8*tlen +: 8] = hold_buf[i];
          tlen++;
        end
        tail[8*tlen +: 8] = b;
        tlen++;
        i = 0;
        while (i < tlen) begin
          l = lead_len(tail[8*i +: 8]);
          if (l == 1) begin
            add_cp({13'd0, tail[8*i +: 8]}, 1'b0);
            i++;
          end else if (l >= 2 && i + l <= tlen) begin
            add_cp(join_bytes(tail >> (8*i), l), 1'b0);
            i += l;
          end else begin
            add_cp(ReplCp, 1'b1);
            i++;
          end
        end
      end
    end
    // string end marks the final code point of the step
    if (lst) begin
      if (cp_expect.size() > n0) begin
        r      = cp_expect.pop_back();
        r.last = 1'b1;
        cp_expect.insert(cp_expect.size(), r);
      end
      hold_cnt = 0;
    end
  endfunction

  function automatic void queue_byte(input logic [ByteW-1:0] b, input logic lst);
    byte_req_t q;
    q.data = b;
    q.last = lst;
    byte_reqs.insert(byte_reqs.size(), q);
  endfunction

  function automatic logic [ByteW-1:0] lead_byte(input int unsigned len);
    if (len == 2) return {3'b110, 5'($urandom_range(0, 31))};
    if (len == 3) return {4'b1110, 4'($urandom_range(0, 15))};
    return {5'b11110, 3'($urandom_range(0, 7))};
  endfunction

  // continuation bytes are absorbed whatever their value
  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // stretches with no idling on either side
  assign burst = ((sent_cnt / 40) % 4) == 3;

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tx_busy && in_taken) tx_busy = 1'b0;
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (byte_reqs.size() != 0) begin
          tx_cur  = byte_reqs.pop_front();
          tx_busy = 1'b1;
          sent_cnt++;
          tx_wait = burst ? 0 : $urandom_range(0, 7);
        end
      end
      s_axis_tvalid_i <= tx_busy;
      s_axis_tdata_i  <= tx_cur.data;
      s_axis_tlast_i  <= tx_cur.last;
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) rx_wait = burst ? 0 : $urandom_range(0, 7);
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // prediction on accepted requests, checking of accepted results
  always @(posedge clk_i) begin
    res_t e;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_axis_tvalid_i && s_axis_tready_o;
      out_taken <= m_axis_tvalid_o && m_axis_tready_i;
      if (s_axis_tvalid_i && s_axis_tready_o) decode_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (cp_expect.size() == 0) begin
          $error("unexpected result: code_point %h", m_axis_tdata_o[CpW-1:0]);
          err_cnt++;
        end else begin
          e = cp_expect.pop_front();
          if (m_axis_tdata_o[CpW-1:0] !== e.cp) begin
            $error("code_point: expected %h, got %h", e.cp, m_axis_tdata_o[CpW-1:0]);
            err_cnt++;
          end
          if (m_axis_tdata_o[OutDW-1:CpW] !== '0) begin
            $error("tdata padding: expected 0, got %h", m_axis_tdata_o[OutDW-1:CpW]);
            err_cnt++;
          end
          if (m_axis_tuser_o !== e.sub) begin
            $error("substituted: expected %b, got %b", e.sub, m_axis_tuser_o);
            err_cnt++;
          end
          if (m_axis_tlast_o !== e.last) begin
            $error("string_end: expected %b, got %b", e.last, m_axis_tlast_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [ByteW-1:0] sbuf[$];
    int unsigned      rand_cnt;
    int unsigned      n_chars;
    int unsigned      pick;
    int unsigned      len;
    int unsigned      n_cont;
    logic             cut_tail;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    rst_ni          = 1'b0;
    hold_cnt        = 0;
    err_cnt         = 0;
    cycle_cnt       = 0;
    sent_cnt        = 0;
    tx_busy         = 1'b0;
    tx_wait         = 0;
    rx_wait         = 0;
    tx_cur          = '0;
    rand_cnt        = 0;

    // ascii extremes
    queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b1);
    // overlong two-byte form, largest two-byte form
    queue_byte(8'hC0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hDF, 1'b0); queue_byte(8'hBF, 1'b1);
    // surrogate, four-byte lead with odd bytes absorbed, completed on the last byte
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hF7, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h3F, 1'b0);
    queue_byte(8'h00, 1'b1);
    // invalid leads and stray continuations
    queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hF8, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'h41, 1'b1);
    // multi-byte lead as the last byte
    queue_byte(8'hE1, 1'b1);
    // incomplete tail holding a complete two-byte sequence
    queue_byte(8'hF0, 1'b0); queue_byte(8'hC3, 1'b0); queue_byte(8'hA9, 1'b1);
    // incomplete tail giving three results
    queue_byte(8'hF4, 1'b0); queue_byte(8'h41, 1'b0); queue_byte(8'h42, 1'b1);
    // incomplete tail with a lone continuation
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);

    // random strings, mostly well formed
    while (rand_cnt < RandBytes) begin
      n_chars  = $urandom_range(1, 6);
      cut_tail = ($urandom_range(0, 9) < 3);
      sbuf.delete();
      for (int unsigned c = 0; c < n_chars; c++) begin
        pick = $urandom_range(0, 99);
        if (cut_tail && c == n_chars - 1) pick = 90;
        if (pick < 20) begin
          sbuf.insert(sbuf.size(), 8'($urandom_range(0, 127)));
        end else if (pick < 70) begin
          len = (pick < 40) ? 2 : (pick < 55) ? 3 : 4;
          sbuf.insert(sbuf.size(), lead_byte(len));
          for (int unsigned k = 1; k < len; k++) sbuf.insert(sbuf.size(), cont_byte());
        end else if (pick < 85) begin
          sbuf.insert(sbuf.size(), 8'($urandom_range(0, 255)));
        end else begin
          // truncated sequence
          len    = $urandom_range(2, 4);
          n_cont = $urandom_range(0, len - 2);
          sbuf.insert(sbuf.size(), lead_byte(len));
          for (int unsigned k = 0; k < n_cont; k++) sbuf.insert(sbuf.size(), cont_byte());
        end
      end
      for (int unsigned k = 0; k < sbuf.size(); k++) queue_byte(sbuf[k], k == sbuf.size() - 1);
      rand_cnt += sbuf.size();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all requests and results, then a short drain
    while (byte_reqs.size() != 0 || tx_busy || cp_expect.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (cp_expect.size() != 0) begin
      $error("%0d expected code points never arrived", cp_expect.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
